/* src/rpse_pkg.sv */
// ----------------------------------------------------------------------------
// rpse_pkg
// Shared types and character codes for the reversed prefix stack evaluator.
// ----------------------------------------------------------------------------
package rpse_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_DIVZERO   = 2'd3;

  typedef enum logic [1:0] {
    OP_DIV = 2'd0,
    OP_MOD = 2'd1,
    OP_POW = 2'd2
  } iter_op_t;

  typedef struct packed {
    logic       start;
    iter_op_t   op;
    logic [31:0] a;
    logic [31:0] b;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [31:0] result;
  } iter_rsp_t;

endpackage

/* src/rpse_iter_unit.sv */
// ----------------------------------------------------------------------------
// rpse_iter_unit
// Shared iterative unit: signed division, modulo and power, one bit a cycle.
// ----------------------------------------------------------------------------
module rpse_iter_unit (
  input  logic               clk,
  input  logic               rst,
  input  rpse_pkg::iter_req_t req,
  output rpse_pkg::iter_rsp_t rsp
);
  import rpse_pkg::*;

  logic        busy;
  logic        done;
  logic [5:0]  count;
  iter_op_t    op;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] divisor;
  logic        neg_q;
  logic        neg_r;
  logic [31:0] base;
  logic [31:0] acc;
  logic [31:0] expo;
  logic [31:0] result;

  logic [32:0] trial;
  logic [31:0] rem_shift;
  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic        finish;

  assign mag_a     = req.a[31] ? (32'd0 - req.a) : req.a;
  assign mag_b     = req.b[31] ? (32'd0 - req.b) : req.b;
  assign rem_shift = {rem[30:0], quo[31]};
  assign trial     = {1'b0, rem_shift} - {1'b0, divisor};
  assign finish    = busy && ((op == OP_POW) ? (expo == 32'd0 || count == 6'd32) :
                                               (count == 6'd32));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= 6'd0;
    end else begin
      done <= finish;
      if (req.start) begin
        busy  <= 1'b1;
        count <= 6'd0;
      end else if (busy) begin
        if (finish) busy <= 1'b0;
        count <= count + 6'd1;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (req.start) begin
      op      <= req.op;
      rem     <= 32'd0;
      quo     <= mag_a;
      divisor <= mag_b;
      neg_q   <= req.a[31] ^ req.b[31];
      neg_r   <= req.a[31];
      base    <= req.a;
      acc     <= (req.b[31] && req.op == OP_POW) ? 32'd0 : 32'd1;
      expo    <= req.b[31] ? 32'd0 : req.b;
    end else if (busy) begin
      if (op == OP_POW) begin
        if (expo != 32'd0) begin
          if (expo[0]) acc <= acc * base;
          base <= base * base;
          expo <= {1'b0, expo[31:1]};
        end
      end else if (count != 6'd32) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[30:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    case (op)
      OP_DIV:  result = neg_q ? (32'd0 - quo) : quo;
      OP_MOD:  result = neg_r ? (32'd0 - rem) : rem;
      default: result = acc;
    endcase
  end

  assign rsp.done   = done;
  assign rsp.busy   = busy;
  assign rsp.result = result;

endmodule

/* src/reversed_prefix_stack_evaluator.sv */
// ----------------------------------------------------------------------------
// reversed_prefix_stack_evaluator
// Evaluates a reversed prefix expression on an operand stack held in memory.
// ----------------------------------------------------------------------------
//  channel | direction | fields        | handshake
//  in      | input     | symbol, last  | in_valid / in_ready
//  out     | output    | value, status | out_valid / out_ready
//
//  A space or a digit is handled in the idle state; + - * pop two memory
//  operands, then push; / % ^ pop two and, but for a zero divisor, use the
//  shared one-bit-a-cycle iterative unit, ^ ending once its exponent is spent.
//  A last request adds the top-of-stack read and the result. Reset clears
//  pointer and error status; the stack memory needs no clearing. A result held
//  in the output register blocks only the next last request; others proceed.
// ----------------------------------------------------------------------------
module reversed_prefix_stack_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  symbol,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] value,
  output logic [1:0]  status
);
  import rpse_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_POPA  = 7'b0000010,
    S_POPB  = 7'b0000100,
    S_CALC  = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_TOP   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t      state;
  logic [PW-1:0] sp;
  logic [1:0]  err;
  logic [7:0]  opc;
  logic        fin;
  logic [31:0] opa;
  logic        a_ok;
  logic        b_ok;
  logic [31:0] rd_data;
  logic [31:0] stack_mem [STACK_DEPTH];
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] wr_data;
  logic [AW-1:0] rd_addr;
  iter_req_t   ireq;
  iter_rsp_t   irsp;

  logic is_op;
  logic [1:0] err_ovf;
  always_comb begin
    is_op = symbol inside {CH_POW, CH_MOD, CH_DIV, CH_MUL, CH_ADD, CH_SUB};
  end

  assign in_ready = (state == S_IDLE) && !(last && out_valid);
  assign rd_addr  = AW'(sp - PW'(1));

  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[wr_addr] <= wr_data;
    rd_data <= stack_mem[rd_addr];
  end

  rpse_iter_unit u_iter (
    .clk (clk),
    .rst (rst),
    .req (ireq),
    .rsp (irsp)
  );

  logic [31:0] opb;
  logic [31:0] simple;
  assign opb = b_ok ? rd_data : 32'd0;
  always_comb begin
    case (opc)
      CH_ADD:  simple = opa + opb;
      CH_SUB:  simple = opa - opb;
      default: simple = opa * opb;
    endcase
  end

  logic divz;
  assign divz = (opc == CH_DIV || opc == CH_MOD) && opb == 32'd0;

  always_comb begin
    ireq.start = (state == S_CALC) && !divz &&
                 (opc == CH_DIV || opc == CH_MOD || opc == CH_POW);
    ireq.op    = (opc == CH_DIV) ? OP_DIV : ((opc == CH_MOD) ? OP_MOD : OP_POW);
    ireq.a     = opa;
    ireq.b     = opb;
  end

  logic [31:0] push_val;
  logic        push_go;
  logic [1:0]  err_next;
  always_comb begin
    push_go  = 1'b0;
    push_val = simple;
    err_next = err;
    if (state == S_IDLE && in_valid && in_ready && symbol != CH_SPACE && !is_op) begin
      push_go  = 1'b1;
      push_val = 32'(symbol) - 32'd48;
    end else if (state == S_CALC) begin
      if (!a_ok || !b_ok) err_next = ST_UNDERFLOW;
      if (divz) begin
        push_go = 1'b1;
        push_val = 32'd0;
        if (err_next == ST_OK) err_next = ST_DIVZERO;
      end else if (!ireq.start) begin
        push_go = 1'b1;
      end
    end else if (state == S_WAIT && irsp.done) begin
      push_go  = 1'b1;
      push_val = irsp.result;
    end
    if (err != ST_OK) err_next = err;
    if (push_go && sp >= FULL && err_next == ST_OK) err_next = ST_OVERFLOW;
    if (state == S_FIN) err_next = ST_OK;
  end
  assign err_ovf = err_next;

  assign wr_en   = push_go && sp < FULL;
  assign wr_addr = AW'(sp);
  assign wr_data = push_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      err <= err_ovf;
      if (wr_en) sp <= sp + PW'(1);
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            opc <= symbol;
            fin <= last;
            if (symbol != CH_SPACE && is_op) state <= S_POPA;
            else if (last) state <= S_TOP;
          end
        end
        S_POPA: begin
          a_ok <= sp != '0;
          if (sp != '0) sp <= sp - PW'(1);
          state <= S_POPB;
        end
        S_POPB: begin
          opa  <= a_ok ? rd_data : 32'd0;
          b_ok <= sp != '0;
          if (sp != '0) sp <= sp - PW'(1);
          state <= S_CALC;
        end
        S_CALC: begin
          if (ireq.start) state <= S_WAIT;
          else if (fin) state <= S_TOP;
          else state <= S_IDLE;
        end
        S_WAIT: begin
          if (irsp.done) state <= fin ? S_TOP : S_IDLE;
        end
        S_TOP: begin
          state <= S_FIN;
        end
        S_FIN: begin
          value     <= (sp == '0) ? 32'sd0 : rd_data;
          status    <= (sp == '0 && err == ST_OK) ? ST_UNDERFLOW : err;
          out_valid <= 1'b1;
          sp        <= '0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/rpse_checker.sv */
// ----------------------------------------------------------------------------
// rpse_checker
// Port-level checks on the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module rpse_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value,
  input logic [1:0]  status
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status))
    else $error("result changed while stalled");

  a_no_last_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(in_ready && last))
    else $error("last request taken while result pending");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_no_result_without_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without pending last request");
endmodule

bind reversed_prefix_stack_evaluator rpse_checker u_rpse_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .last      (last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value     (value),
  .status    (status)
);
